>>> rtl/fbfl_pkg.sv
package fbfl_pkg;

  localparam int POOL_DEPTH = 1024;
  localparam int SLOT_W     = $clog2(POOL_DEPTH);
  localparam int CNTR_W     = SLOT_W + 1;
  localparam int OFF_W      = 22;
  localparam int EXP_W      = 4;
  localparam int SCNT_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [EXP_W-1:0] EXP_MIN = EXP_W'(2);
  localparam logic [EXP_W-1:0] EXP_MAX = EXP_W'(12);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNTR_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_REBUILD = 2'd2
  } req_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_EXP   = CFG_IDX_W'(0),
    CFG_SLOT_COUNT = CFG_IDX_W'(1)
  } cfg_idx_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_REBUILD,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [OFF_W-1:0] offset;
  } in_t;

  typedef struct packed {
    logic             status;
    logic [OFF_W-1:0] offset_res;
  } out_t;

  // next-slot entry; vld clear is the end marker
  typedef struct packed {
    logic  vld;
    slot_t idx;
  } ent_t;

  typedef struct packed {
    logic [EXP_W-1:0]  size_exponent;
    logic [SCNT_W-1:0] slot_count;
  } cfg_t;

  typedef struct packed {
    logic  we;
    slot_t waddr;
    ent_t  wdata;
    slot_t raddr;
  } mem_req_t;

  typedef struct packed {
    logic load;
    out_t data;
  } resp_t;

  function automatic logic [EXP_W-1:0] eff_exp(input logic [EXP_W-1:0] e);
    logic [EXP_W-1:0] r;
    r = e;
    if (e < EXP_MIN) r = EXP_MIN;
    if (e > EXP_MAX) r = EXP_MAX;
    return r;
  endfunction

endpackage

>>> rtl/fbfl_ram.sv
module fbfl_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/fbfl_ctrl.sv
module fbfl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  fbfl_pkg::in_t      in_data,
  output logic               busy,
  input  fbfl_pkg::cfg_t     cfg,
  output fbfl_pkg::mem_req_t mem_req,
  input  fbfl_pkg::ent_t     mem_rdata,
  input  logic               out_free,
  output fbfl_pkg::resp_t    resp
);

  fbfl_pkg::state_t        state_r, state_nxt;
  fbfl_pkg::slot_t         head_r, head_nxt;
  logic                    head_vld_r, head_vld_nxt;
  fbfl_pkg::slot_t         idx_r, idx_nxt;
  fbfl_pkg::cnt_t          cnt_r, cnt_nxt;
  fbfl_pkg::out_t          res_r, res_nxt;

  logic [fbfl_pkg::EXP_W-1:0] exp_eff;
  logic [fbfl_pkg::OFF_W-1:0] free_shr;
  logic                       free_in_pool;
  fbfl_pkg::cnt_t             n_clamp;
  fbfl_pkg::cnt_t             idx_inc;
  logic                       idx_last;
  fbfl_pkg::out_t             alloc_res;

  assign exp_eff      = fbfl_pkg::eff_exp(cfg.size_exponent);
  assign free_shr     = in_data.offset >> exp_eff;
  assign free_in_pool = ((free_shr >> fbfl_pkg::SLOT_W) == '0);
  assign n_clamp      = (32'(cfg.slot_count) > fbfl_pkg::POOL_DEPTH)
                        ? fbfl_pkg::cnt_t'(fbfl_pkg::POOL_DEPTH)
                        : fbfl_pkg::cnt_t'(cfg.slot_count);

  // single rebuild counter: one increment and one compare per cycle
  assign idx_inc  = {1'b0, idx_r} + fbfl_pkg::cnt_t'(1);
  assign idx_last = (idx_inc == cnt_r);

  assign alloc_res.status     = 1'b0;
  assign alloc_res.offset_res = fbfl_pkg::OFF_W'(head_r) << exp_eff;

  assign busy = (state_r != fbfl_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= fbfl_pkg::ST_IDLE;
      head_vld_r <= 1'b0;
      head_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      head_vld_r <= head_vld_nxt;
      head_r     <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    head_vld_nxt  = head_vld_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = free_shr[fbfl_pkg::SLOT_W-1:0];
    mem_req.wdata = '0;
    mem_req.raddr = head_r;
    resp.load     = 1'b0;
    resp.data     = res_r;

    case (state_r)
      fbfl_pkg::ST_IDLE: begin
        if (in_valid) begin
          res_nxt   = '0;
          state_nxt = fbfl_pkg::ST_RESP;
          case (in_data.req_type)
            fbfl_pkg::REQ_ALLOC: begin
              if (head_vld_r) begin
                state_nxt = fbfl_pkg::ST_ALLOC;
              end else begin
                res_nxt.status = 1'b1;
              end
            end
            fbfl_pkg::REQ_FREE: begin
              if (free_in_pool) begin
                mem_req.we        = 1'b1;
                mem_req.wdata.vld = head_vld_r;
                mem_req.wdata.idx = head_vld_r ? head_r : '0;
                head_nxt          = free_shr[fbfl_pkg::SLOT_W-1:0];
                head_vld_nxt      = 1'b1;
              end
            end
            fbfl_pkg::REQ_REBUILD: begin
              if (n_clamp == '0) begin
                head_vld_nxt = 1'b0;
                head_nxt     = '0;
              end else begin
                cnt_nxt   = n_clamp;
                idx_nxt   = '0;
                state_nxt = fbfl_pkg::ST_REBUILD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      fbfl_pkg::ST_ALLOC: begin
        // head entry read issued at accept, data registered now
        head_vld_nxt = mem_rdata.vld;
        head_nxt     = mem_rdata.vld ? mem_rdata.idx : '0;
        res_nxt      = alloc_res;
        if (out_free) begin
          resp.load = 1'b1;
          resp.data = alloc_res;
          state_nxt = fbfl_pkg::ST_IDLE;
        end else begin
          state_nxt = fbfl_pkg::ST_RESP;
        end
      end
      fbfl_pkg::ST_REBUILD: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        if (idx_last) begin
          mem_req.wdata = '0;
          head_nxt      = '0;
          head_vld_nxt  = 1'b1;
          state_nxt     = fbfl_pkg::ST_RESP;
        end else begin
          mem_req.wdata.vld = 1'b1;
          mem_req.wdata.idx = idx_inc[fbfl_pkg::SLOT_W-1:0];
          idx_nxt           = idx_inc[fbfl_pkg::SLOT_W-1:0];
        end
      end
      fbfl_pkg::ST_RESP: begin
        if (out_free) begin
          resp.load = 1'b1;
          state_nxt = fbfl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fbfl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/fixed_block_free_list_allocator.sv
// Fixed-size block allocator on a singly linked free list.
//
// Channels:
//   in_*  : one request per transaction (allocate, free, rebuild), valid/stall.
//   out_* : exactly one response per request, in request order, valid/stall.
//   cfg_* : register writes (index 0 size exponent, 1 slot count), valid/ready;
//           cfg_ready is always high, write only while no request is pending.
// Sequencing:
//   free, exhausted allocate, unknown type: accept, then hand over the response.
//   allocate from a non-empty list: one next-slot memory read, then the head
//   update from the registered read data.
//   rebuild: N = min(slot_count, pool depth) slots; the next-slot memory
//   takes one write per cycle, driven by a single counter/compare unit.
//   in_stall is high from the accept until the response is handed to the
//   output register.
// Reset: free list empty (allocate answers exhausted until a rebuild or free),
//   size exponent 2, slot count 1024, output register empty. No clearing pass:
//   the next-slot memory is only read at slots the list has linked.
// Receiver stall: the response holds in the output register; a finished
//   response behind it waits in the sequencer, which stalls new requests.
module fixed_block_free_list_allocator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  fbfl_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fbfl_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbfl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  fbfl_pkg::cfg_t     cfg_r;
  fbfl_pkg::mem_req_t mem_req;
  fbfl_pkg::ent_t     mem_rdata;
  fbfl_pkg::resp_t    resp;
  logic               out_valid_r;
  fbfl_pkg::out_t     out_data_r;
  logic               out_free;
  logic               busy;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size_exponent <= fbfl_pkg::EXP_MIN;
      cfg_r.slot_count    <= fbfl_pkg::SCNT_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fbfl_pkg::CFG_SIZE_EXP:   cfg_r.size_exponent <= cfg_data[fbfl_pkg::EXP_W-1:0];
        fbfl_pkg::CFG_SLOT_COUNT: cfg_r.slot_count    <= cfg_data[fbfl_pkg::SCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer: head register, rebuild walk, response hold
  fbfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .busy      (busy),
    .cfg       (cfg_r),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .out_free  (out_free),
    .resp      (resp)
  );

  assign in_stall = busy;

  // next-slot memory: one write and one registered read per cycle
  fbfl_ram #(
    .DEPTH (fbfl_pkg::POOL_DEPTH),
    .WIDTH ($bits(fbfl_pkg::ent_t))
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // output register; free when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp.load) begin
      out_data_r <= resp.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/fbfl_chk.sv
module fbfl_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input fbfl_pkg::out_t out_data
);

  // one request in flight: accepting makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one in flight");

  // exhausted responses carry a zero offset
  a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.status && (out_data.offset_res != '0)))
    else $error("exhausted response with nonzero offset");

  // leaving reset: output empty, input open
  a_reset_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled response dropped or changed");

endmodule

bind fixed_block_free_list_allocator fbfl_chk u_fbfl_chk (.*);

>>> bench/fixed_block_free_list_allocator_tb.sv
`timescale 1ns / 1ps

module fixed_block_free_list_allocator_tb;

  // Request code the block must treat as a no-op.
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  localparam int CLK_HALF    = 4;
  localparam int RESET_LEN   = 5;
  // A full rebuild walks 1024 slots, and a receiver hold-off adds HOLD_CYCLES.
  localparam int STUCK_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 16;
  localparam int N_PHASES    = 6;
  localparam int N_DIR       = 31;
  localparam int MAX_REPORTS = 10;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // One line of the directed stimulus table. A row either issues a request or
  // writes a register; "typed" rows carry their response inline, the others
  // are scored against the free-list model.
  typedef struct {
    row_kind_t                       kind;
    logic [1:0]                      rtype;
    logic [fbfl_pkg::OFF_W-1:0]      off;
    fbfl_pkg::cfg_idx_e_t            reg_idx;
    logic [fbfl_pkg::CFG_DATA_W-1:0] reg_val;
    bit                              typed;
    fbfl_pkg::out_t                  res;
  } row_t;

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  fbfl_pkg::in_t                   in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  fbfl_pkg::out_t                  out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  fixed_block_free_list_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Free-list model: its own copy of the registers, the head and the link store.
  // ---------------------------------------------------------------------------
  logic [fbfl_pkg::EXP_W-1:0]  sz_exp   = fbfl_pkg::EXP_W'(2);
  logic [fbfl_pkg::SCNT_W-1:0] slot_cnt = fbfl_pkg::SCNT_W'(1024);
  fbfl_pkg::slot_t             head_slot = '0;
  logic                        head_vld  = 1'b0;
  fbfl_pkg::ent_t              link_mem [fbfl_pkg::POOL_DEPTH];

  fbfl_pkg::out_t              resp_q [$];   // responses still owed, oldest first
  logic [fbfl_pkg::OFF_W-1:0]  held_q [$];   // offsets handed out, fodder for frees

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_reqs = 0;      // bumped by the sequence to ask for a hold-off
  int unsigned mismatches = 0;

  // Exponent as the block applies it: clamped to the supported element sizes.
  function automatic int unsigned eff_shift();
    if (sz_exp < fbfl_pkg::EXP_MIN) return fbfl_pkg::EXP_MIN;
    if (sz_exp > fbfl_pkg::EXP_MAX) return fbfl_pkg::EXP_MAX;
    return sz_exp;
  endfunction

  // Applies one request to the model and returns the response it owes.
  function automatic fbfl_pkg::out_t next_response(input fbfl_pkg::in_t req);
    fbfl_pkg::out_t res;
    fbfl_pkg::ent_t nxt;
    int unsigned    sh;
    int unsigned    slot;
    int unsigned    n;
    res = '0;
    sh  = eff_shift();
    case (req.req_type)
      fbfl_pkg::REQ_ALLOC: begin
        if (!head_vld) begin
          res.status = 1'b1;               // empty list: exhausted, nothing moves
        end else begin
          res.offset_res = fbfl_pkg::OFF_W'(32'(head_slot) << sh);
          nxt       = link_mem[head_slot];
          head_vld  = nxt.vld;
          head_slot = nxt.vld ? nxt.idx : '0;
        end
      end
      fbfl_pkg::REQ_FREE: begin
        // low bits of an unaligned offset fall off; slots past the pool are dropped
        slot = req.offset >> sh;
        if (slot < fbfl_pkg::POOL_DEPTH) begin
          link_mem[slot] = '{vld: head_vld, idx: (head_vld ? head_slot : '0)};
          head_slot = fbfl_pkg::slot_t'(slot);
          head_vld  = 1'b1;
        end
      end
      fbfl_pkg::REQ_REBUILD: begin
        n = (slot_cnt > fbfl_pkg::POOL_DEPTH) ? fbfl_pkg::POOL_DEPTH : slot_cnt;
        if (n == 0) begin
          head_vld  = 1'b0;
          head_slot = '0;
        end else begin
          for (int i = 0; i + 1 < n; i++)
            link_mem[i] = '{vld: 1'b1, idx: fbfl_pkg::slot_t'(i + 1)};
          link_mem[n - 1] = '{vld: 1'b0, idx: '0};
          head_slot = '0;
          head_vld  = 1'b1;
        end
      end
      default: ;                           // unknown request type: no state change
    endcase
    return res;
  endfunction

  // Random request, biased toward well-formed traffic: allocations and frees of held
  // blocks; some unaligned, out-of-pool, double or junk frees, rebuilds, unknown types.
  function automatic fbfl_pkg::in_t pick_req();
    fbfl_pkg::in_t r;
    int unsigned   dice;
    int unsigned   sh;
    int            k;
    sh         = eff_shift();
    r.req_type = fbfl_pkg::REQ_ALLOC;
    r.offset   = fbfl_pkg::OFF_W'($urandom);   // junk in the ignored field too
    dice       = $urandom_range(99);
    if (dice < 42) begin
      r.req_type = fbfl_pkg::REQ_ALLOC;
    end else if (dice < 78) begin
      r.req_type = fbfl_pkg::REQ_FREE;
      if (held_q.size() != 0) begin
        k = $urandom_range(held_q.size() - 1);
        r.offset = held_q[k];
        held_q.delete(k);
      end
    end else if (dice < 84) begin
      // any slot of the pool, possibly never linked, with junk low bits
      r.req_type = fbfl_pkg::REQ_FREE;
      r.offset = fbfl_pkg::OFF_W'(($urandom_range(fbfl_pkg::POOL_DEPTH - 1) << sh) |
                                  ($urandom & ((32'd1 << sh) - 1)));
    end else if (dice < 88) begin
      r.req_type = fbfl_pkg::REQ_FREE;     // raw offset, beyond the pool unless the size exponent is large
    end else if (dice < 90) begin
      // free a held block but keep it listed: it may be freed a second time later
      r.req_type = fbfl_pkg::REQ_FREE;
      if (held_q.size() != 0) r.offset = held_q[$urandom_range(held_q.size() - 1)];
    end else if (dice < 95) begin
      r.req_type = fbfl_pkg::REQ_REBUILD;
    end else begin
      r.req_type = REQ_UNKNOWN;
    end
    return r;
  endfunction

  function automatic void flag_miss(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $time, what);
  endfunction

  function automatic row_t req_row(input logic [1:0] t,
                                   input logic [fbfl_pkg::OFF_W-1:0] o,
                                   input bit typed = 1'b0, input logic st = 1'b0,
                                   input logic [fbfl_pkg::OFF_W-1:0] ro = '0);
    row_t r;
    r = '{kind: ROW_REQ, rtype: t, off: o, reg_idx: fbfl_pkg::CFG_SIZE_EXP, reg_val: '0,
          typed: typed, res: '{status: st, offset_res: ro}};
    return r;
  endfunction

  function automatic row_t cfg_row(input fbfl_pkg::cfg_idx_e_t idx,
                                   input logic [fbfl_pkg::CFG_DATA_W-1:0] v);
    row_t r;
    r = '{kind: ROW_CFG, rtype: fbfl_pkg::REQ_ALLOC, off: '0, reg_idx: idx, reg_val: v,
          typed: 1'b0, res: '0};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Valid is lowered only for a gap or a drain, so back-to-back
  // transactions keep it high; the payload moves only after acceptance.
  // ---------------------------------------------------------------------------
  task automatic send_req(input fbfl_pkg::in_t req, input bit typed,
                          input fbfl_pkg::out_t typed_res);
    fbfl_pkg::out_t pred;
    if (cfg_valid) cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    pred = next_response(req);
    if (req.req_type == fbfl_pkg::REQ_REBUILD) held_q.delete();
    if (req.req_type == fbfl_pkg::REQ_ALLOC && !pred.status)
      held_q.push_back(pred.offset_res);
    resp_q.push_back(typed ? typed_res : pred);
  endtask

  // Stop offering and wait until every owed response has been taken.
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk);
  endtask

  // Register write; only issued after a drain. Valid is lowered by the next request.
  task automatic write_reg(input fbfl_pkg::cfg_idx_e_t idx,
                           input logic [fbfl_pkg::CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    if (idx == fbfl_pkg::CFG_SIZE_EXP) sz_exp = v[fbfl_pkg::EXP_W-1:0];
    else slot_cnt = v;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall, plus a long hold-off counted here whenever the
  // sequence asks for one, so the block backs up and stalls its input.
  // ---------------------------------------------------------------------------
  int unsigned hold_left  = 0;
  int unsigned holds_done = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != holds_done) begin
      holds_done <= holds_done + 1;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Response scoreboard and watchdog. Outputs are read at the edge, before the
  // block's registers update, so the sampled values are the ones handed over.
  int unsigned stuck_cycles = 0;

  always @(posedge clk) begin : scoreboard
    fbfl_pkg::out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (resp_q.size() == 0) begin
          flag_miss($sformatf("unexpected response status=%0d offset=0x%06h",
                              out_data.status, out_data.offset_res));
        end else begin
          want = resp_q.pop_front();
          if (out_data.status !== want.status)
            flag_miss($sformatf("status exp=%0d got=%0d", want.status, out_data.status));
          if (out_data.offset_res !== want.offset_res)
            flag_miss($sformatf("offset exp=0x%06h got=0x%06h",
                                want.offset_res, out_data.offset_res));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        stuck_cycles <= 0;
      else
        stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("[%0t] watchdog: no transaction for %0d cycles", $time, STUCK_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  row_t dir_tab [N_DIR];

  initial begin : sequence_main
    fbfl_pkg::in_t               req;
    logic [fbfl_pkg::EXP_W-1:0]  ph_exp;
    logic [fbfl_pkg::SCNT_W-1:0] ph_cnt;
    int                          ph_items;

    for (int i = 0; i < fbfl_pkg::POOL_DEPTH; i++) link_mem[i] = '0;

    // Directed part: corners that can be read straight off the list rules.
    dir_tab = '{
      req_row(fbfl_pkg::REQ_ALLOC,   22'h3FFFFF, 1, 1'b1, 22'h0),  // empty after reset
      req_row(fbfl_pkg::REQ_FREE,    22'h3FFFFF, 1, 1'b0, 22'h0),  // slot past the pool
      req_row(REQ_UNKNOWN,           22'h3FFFFF, 1, 1'b0, 22'h0),
      cfg_row(fbfl_pkg::CFG_SLOT_COUNT, 11'd1),
      req_row(fbfl_pkg::REQ_REBUILD, 22'h3FFFFF, 1, 1'b0, 22'h0),
      req_row(fbfl_pkg::REQ_ALLOC,   22'h0,      1, 1'b0, 22'h0),
      req_row(fbfl_pkg::REQ_ALLOC,   22'h0,      1, 1'b1, 22'h0),  // single slot used up
      cfg_row(fbfl_pkg::CFG_SLOT_COUNT, 11'd0),
      req_row(fbfl_pkg::REQ_REBUILD, 22'h0,      1, 1'b0, 22'h0),
      req_row(fbfl_pkg::REQ_ALLOC,   22'h0,      1, 1'b1, 22'h0),  // zero count: empty
      req_row(fbfl_pkg::REQ_FREE,    22'd7,      1, 1'b0, 22'h0),  // unaligned, unlinked
      req_row(fbfl_pkg::REQ_FREE,    22'd4092,   1, 1'b0, 22'h0),  // last slot of pool
      req_row(fbfl_pkg::REQ_ALLOC,   22'h0,      1, 1'b0, 22'd4092),
      req_row(fbfl_pkg::REQ_ALLOC,   22'h0,      1, 1'b0, 22'd4),
      req_row(fbfl_pkg::REQ_ALLOC,   22'h0,      1, 1'b1, 22'h0),
      req_row(fbfl_pkg::REQ_FREE,    22'd8),                       // double free
      req_row(fbfl_pkg::REQ_FREE,    22'd8),
      req_row(fbfl_pkg::REQ_ALLOC,   22'h0),
      req_row(fbfl_pkg::REQ_ALLOC,   22'h0),
      cfg_row(fbfl_pkg::CFG_SIZE_EXP, 11'd0),                      // below range, acts as 2
      cfg_row(fbfl_pkg::CFG_SLOT_COUNT, 11'd2047),                 // above the pool depth
      req_row(fbfl_pkg::REQ_REBUILD, 22'h0),
      req_row(fbfl_pkg::REQ_ALLOC,   22'h0,      1, 1'b0, 22'h0),
      req_row(fbfl_pkg::REQ_ALLOC,   22'h0,      1, 1'b0, 22'd4),
      req_row(fbfl_pkg::REQ_FREE,    22'h3FFFFF),
      cfg_row(fbfl_pkg::CFG_SIZE_EXP, 11'd15),                     // above range, acts as 12
      req_row(fbfl_pkg::REQ_ALLOC,   22'h0,      1, 1'b0, 22'h002000),
      req_row(fbfl_pkg::REQ_FREE,    22'h3FFFFF),                  // slot 1023 at 4 KiB
      req_row(fbfl_pkg::REQ_ALLOC,   22'h0,      1, 1'b0, 22'h3FF000),
      cfg_row(fbfl_pkg::CFG_SIZE_EXP, 11'h7FB),                    // upper data bits unused
      req_row(fbfl_pkg::REQ_ALLOC,   22'h0)
    };

    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        req = '{req_type: dir_tab[i].rtype, offset: dir_tab[i].off};
        send_req(req, dir_tab[i].typed, dir_tab[i].res);
      end
    end

    // Random part: two settings per idling mode, each started from a rebuild.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin ph_exp = 4'd2;  ph_cnt = 11'd16;   end
        1: begin ph_exp = 4'd12; ph_cnt = 11'd1024; end
        2: begin
          ph_exp = fbfl_pkg::EXP_W'($urandom_range(3, 11));
          ph_cnt = fbfl_pkg::SCNT_W'($urandom_range(1, 8));
        end
        3: begin ph_exp = 4'd0;  ph_cnt = 11'd2047; end
        4: begin ph_exp = 4'd15; ph_cnt = 11'd0;    end
        default: begin
          ph_exp = fbfl_pkg::EXP_W'($urandom_range(15));
          ph_cnt = fbfl_pkg::SCNT_W'($urandom_range(1, 48));
        end
      endcase
      send_idle_pct = (ph < 2) ? 26 : (ph < 4) ? 63 : 0;
      recv_idle_pct = (ph < 2) ? 63 : (ph < 4) ? 26 : 0;
      ph_items      = (ph == N_PHASES - 1) ? 350 : 300;
      write_reg(fbfl_pkg::CFG_SIZE_EXP, fbfl_pkg::CFG_DATA_W'(ph_exp));
      write_reg(fbfl_pkg::CFG_SLOT_COUNT, ph_cnt);
      req = '{req_type: fbfl_pkg::REQ_REBUILD, offset: fbfl_pkg::OFF_W'($urandom)};
      send_req(req, 1'b0, '0);
      for (int n = 0; n < ph_items; n++) begin
        // mid-run back-pressure: receiver frozen while the sender keeps offering
        if (ph == N_PHASES - 1 && n == 150) hold_reqs <= hold_reqs + 1;
        send_req(pick_req(), 1'b0, '0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (resp_q.size() != 0) flag_miss($sformatf("%0d responses never arrived", resp_q.size()));
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/fbfl_pkg.sv
rtl/fbfl_ram.sv
rtl/fbfl_ctrl.sv
rtl/fixed_block_free_list_allocator.sv
rtl/fbfl_chk.sv
bench/fixed_block_free_list_allocator_tb.sv
